FILE: design/mslgg_pkg.sv
// Shared types and constants of the multi-stop gradient generator.
`timescale 1ns / 1ps
package mslgg_pkg;

  localparam int unsigned NUM_CH = 4;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ACC_W  = 26;
  localparam int unsigned QUO_W  = 24;
  localparam int unsigned STOP_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIRECTION    = 2'd2;
  localparam logic [1:0] REG_STOP_COUNT   = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PRODUCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_SEGW,
    ST_CHK,
    ST_RD0,
    ST_RD1,
    ST_LAT1,
    ST_DIV,
    ST_DIVW,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic stop_we;
    logic norm;
    logic seg_go;
    logic seg_take;
    logic begin_run;
    logic rd_hi;
    logic lat0;
    logic lat1;
    logic ch_clr;
    logic ch_go;
    logic ch_take;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic seg_dirty;
    logic div_done;
    logic run_start;
    logic ch_last;
    logic out_free;
    logic nseg;
  } dp_status_t;

endpackage

FILE: design/mslgg_if.sv
// Handshake channels of the gradient generator: stop/produce items in, pixels out.
`timescale 1ns / 1ps
interface mslgg_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] stop_index;
  logic [7:0] stop_red;
  logic [7:0] stop_green;
  logic [7:0] stop_blue;
  logic [7:0] stop_alpha;
  modport source (output valid, cmd, stop_index, stop_red, stop_green, stop_blue,
                  stop_alpha, input ready);
  modport sink (input valid, cmd, stop_index, stop_red, stop_green, stop_blue,
                stop_alpha, output ready);
endinterface

interface mslgg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic [7:0] pix_alpha;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, row_end,
                  frame_end, input ready);
  modport sink (input valid, pix_red, pix_green, pix_blue, pix_alpha, row_end,
                frame_end, output ready);
endinterface

FILE: design/multi_stop_linear_gradient_generator.sv
// Top level of the multi-stop linear gradient generator.
`timescale 1ns / 1ps
// Usage:
//  - in_chan carries items: cmd 0 loads colour stop stop_index, cmd 1 asks
//    for the next pixel of the frame in raster order.
//  - out_chan returns one RGBA pixel per produce item, with row_end and
//    frame_end flags; loads return nothing.
//  - cfg_we/cfg_addr/cfg_wdata write frame_width (0), frame_height (1),
//    direction (2) and stop_count (3); write only while the block is idle.
// Sequencing:
//  - A load is written to the stop table from the idle state. A produce within
//    a segment passes ST_CHK and ST_OUT before its pixel is registered.
//  - At the start of a run along the gradient axis, and at each segment
//    boundary, the four channel steps are divided out in turn on one shared
//    restoring divider; the next item waits until they are done.
//  - The first produce after a register write first recomputes the segment
//    length on the same divider.
// Reset: registers return to width 1, height 1, direction 0, two stops;
//  counters and accumulators clear. The stop table holds no reset value.
// Stall: the pixel register holds while out_chan.ready is low; one more item
//  is taken and worked on, and its pixel waits until the register frees.
module multi_stop_linear_gradient_generator #(
  parameter int unsigned MAX_STOPS = 16,
  parameter int unsigned MAX_SIZE  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  mslgg_in_if.sink    in_chan,
  mslgg_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import mslgg_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequence each transfer through the datapath.
  mslgg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_cmd   (in_chan.cmd),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  mslgg_dp #(.MAX_STOPS(MAX_STOPS), .MAX_SIZE(MAX_SIZE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .stop_index (in_chan.stop_index),
    .stop_red   (in_chan.stop_red),
    .stop_green (in_chan.stop_green),
    .stop_blue  (in_chan.stop_blue),
    .stop_alpha (in_chan.stop_alpha),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .pix_red    (out_chan.pix_red),
    .pix_green  (out_chan.pix_green),
    .pix_blue   (out_chan.pix_blue),
    .pix_alpha  (out_chan.pix_alpha),
    .row_end    (out_chan.row_end),
    .frame_end  (out_chan.frame_end)
  );
endmodule

FILE: design/mslgg_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mslgg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: design/mslgg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mslgg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mslgg_pkg::QUO_W-1:0]  dividend,
  input  logic [mslgg_pkg::DIM_W-1:0]  divisor,
  output logic [mslgg_pkg::QUO_W-1:0]  quotient,
  output logic                         done
);
  import mslgg_pkg::*;

  localparam int unsigned CW = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIM_W:0]   rem_sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_sh   = {rem_r, quo_r[QUO_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(QUO_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = DIM_W'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIM_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

FILE: design/mslgg_dp.sv
// Datapath: registers, counters, stop memory, accumulators, divider and pixel register.
`timescale 1ns / 1ps
module mslgg_dp #(
  parameter int unsigned MAX_STOPS = 16,
  parameter int unsigned MAX_SIZE  = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mslgg_pkg::ctl_cmd_t   cmd,
  output mslgg_pkg::dp_status_t status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [12:0]           cfg_wdata,
  input  logic [3:0]            stop_index,
  input  logic [7:0]            stop_red,
  input  logic [7:0]            stop_green,
  input  logic [7:0]            stop_blue,
  input  logic [7:0]            stop_alpha,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            pix_red,
  output logic [7:0]            pix_green,
  output logic [7:0]            pix_blue,
  output logic [7:0]            pix_alpha,
  output logic                  row_end,
  output logic                  frame_end
);
  import mslgg_pkg::*;

  localparam int unsigned AW       = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned SIZE_CAP = (MAX_SIZE > 8191) ? 8191 : MAX_SIZE;
  localparam int unsigned NMAX     = (MAX_STOPS > 31) ? 31 : MAX_STOPS;
  localparam logic [DIM_W-1:0] SIZE_MAX_C = DIM_W'(SIZE_CAP);
  localparam logic [CNT_W-1:0] STOP_MAX_C = CNT_W'(NMAX);

  logic [DIM_W-1:0] fw_r, fh_r;
  logic             dir_r;
  logic [CNT_W-1:0] sc_r;
  logic             dirty_r;
  logic [DIM_W-1:0] seg_r;
  logic [DIM_W-1:0] col_r, row_r, spos_r;
  logic [CNT_W-1:0] sidx_r;
  logic [ACC_W-1:0] acc_r [NUM_CH];
  logic [ACC_W-1:0] step_r [NUM_CH];
  logic [1:0]       ch_r;
  logic [STOP_W-1:0] c0_r, c1_r;
  logic             out_valid_r;
  logic [CH_W-1:0]  pix_r [NUM_CH];
  logic             row_end_r, frame_end_r;

  logic [DIM_W-1:0] w, h, len, pos, spos_inc;
  logic [CNT_W-1:0] n, count, cnt_m1, c1_idx, sidx_inc;
  logic             multi, rend, fend, adv, seg_more, use_c1;
  logic [AW-1:0]    raddr;
  logic [STOP_W-1:0] rdata;
  logic             stop_we;
  logic [CH_W-1:0]  a0, a1, mag;
  logic [CH_W:0]    diff;
  logic             neg;
  logic [QUO_W-1:0] prod, div_a, quo;
  logic [DIM_W-1:0] div_b;
  logic             div_go, div_done;
  logic [ACC_W-1:0] step_new;

  always_comb begin
    w = (fw_r == '0) ? DIM_W'(1) : ((fw_r > SIZE_MAX_C) ? SIZE_MAX_C : fw_r);
    h = (fh_r == '0) ? DIM_W'(1) : ((fh_r > SIZE_MAX_C) ? SIZE_MAX_C : fh_r);
    n = (sc_r == '0) ? CNT_W'(1) : ((sc_r > STOP_MAX_C) ? STOP_MAX_C : sc_r);
    len   = dir_r ? h : w;
    pos   = dir_r ? row_r : col_r;
    multi = n > CNT_W'(2);
    count = ({{(DIM_W-CNT_W){1'b0}}, n} < len) ? n : len[CNT_W-1:0];
    cnt_m1 = (count > CNT_W'(1)) ? count - CNT_W'(1) : CNT_W'(1);
    rend = col_r == w - DIM_W'(1);
    fend = rend && (row_r == h - DIM_W'(1));
    adv  = !dir_r || rend;
    sidx_inc = sidx_r + CNT_W'(1);
    spos_inc = spos_r + DIM_W'(1);
    seg_more = multi && (sidx_inc < count);
    c1_idx = multi ? sidx_inc : ((n >= CNT_W'(2)) ? CNT_W'(1) : CNT_W'(0));
    use_c1 = !multi || seg_more;
    raddr  = cmd.rd_hi ? AW'(c1_idx) : AW'(sidx_r);
    stop_we = cmd.stop_we && (32'(stop_index) < MAX_STOPS);
  end

  mslgg_ram #(.WIDTH(STOP_W), .DEPTH(MAX_STOPS)) u_stops (
    .clk   (clk),
    .we    (stop_we),
    .waddr (AW'(stop_index)),
    .wdata ({stop_alpha, stop_blue, stop_green, stop_red}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Divider operands: len over count-1 for seg_go, else |c1 - c0| times the scale.
  always_comb begin
    a0   = c0_r[8*ch_r +: 8];
    a1   = c1_r[8*ch_r +: 8];
    diff = {1'b0, a1} - {1'b0, a0};
    neg  = diff[CH_W];
    mag  = neg ? CH_W'(-diff) : diff[CH_W-1:0];
    if (multi) begin
      prod = {mag, 16'b0} + {8'b0, mag, 8'b0} + {16'b0, mag};
    end else begin
      prod = {mag, 16'b0};
    end
    div_go = cmd.seg_go || cmd.ch_go;
    div_a  = cmd.seg_go ? QUO_W'(len) : prod;
    div_b  = cmd.seg_go ? DIM_W'(cnt_m1) : (multi ? seg_r : len);
    step_new = neg ? ACC_W'(-{2'b0, quo}) : {2'b0, quo};
  end

  mslgg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= DIM_W'(1);
      fh_r    <= DIM_W'(1);
      dir_r   <= 1'b0;
      sc_r    <= CNT_W'(2);
      dirty_r <= 1'b1;
      col_r   <= '0;
      row_r   <= '0;
      spos_r  <= '0;
      sidx_r  <= '0;
      ch_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        acc_r[i]  <= '0;
        step_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        dirty_r <= 1'b1;
        unique case (cfg_addr)
          REG_FRAME_WIDTH:  fw_r  <= cfg_wdata;
          REG_FRAME_HEIGHT: fh_r  <= cfg_wdata;
          REG_DIRECTION:    dir_r <= cfg_wdata[0];
          REG_STOP_COUNT:   sc_r  <= cfg_wdata[CNT_W-1:0];
        endcase
      end else if (cmd.seg_take) begin
        dirty_r <= 1'b0;
      end
      if (cmd.norm) begin
        if (col_r >= w) col_r <= '0;
        if (row_r >= h) row_r <= '0;
      end
      if (cmd.begin_run) begin
        sidx_r <= '0;
        spos_r <= '0;
      end
      if (cmd.lat0) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (multi) begin
            acc_r[i] <= ACC_W'({rdata[8*i +: 8], 16'b0}) + ACC_W'({rdata[8*i +: 8], 8'b0})
                      + ACC_W'(rdata[8*i +: 8]);
          end else begin
            acc_r[i] <= ACC_W'({rdata[8*i +: 8], 16'b0});
          end
        end
      end
      if (cmd.ch_clr) begin
        ch_r <= '0;
      end else if (cmd.ch_take) begin
        step_r[ch_r] <= step_new;
        ch_r <= ch_r + 2'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        if (adv) begin
          for (int i = 0; i < NUM_CH; i++) begin
            acc_r[i] <= acc_r[i] + step_r[i];
          end
          if (seg_more) begin
            // Advance within the segment; roll over to the next one at its end.
            if (spos_inc >= seg_r) begin
              spos_r <= '0;
              sidx_r <= sidx_inc;
            end else begin
              spos_r <= spos_inc;
            end
          end
        end
        if (rend) begin
          col_r <= '0;
          row_r <= fend ? '0 : row_r + DIM_W'(1);
        end else begin
          col_r <= col_r + DIM_W'(1);
        end
      end
    end
    if (cmd.seg_take) begin
      seg_r <= quo[DIM_W-1:0];
    end
    if (cmd.lat0) begin
      c0_r <= rdata;
    end
    if (cmd.lat1) begin
      c1_r <= use_c1 ? rdata : c0_r;
    end
    if (cmd.emit) begin
      for (int i = 0; i < NUM_CH; i++) begin
        pix_r[i] <= acc_r[i][23:16];
      end
      row_end_r   <= rend;
      frame_end_r <= fend;
    end
  end

  always_comb begin
    status.seg_dirty = dirty_r;
    status.div_done  = div_done;
    status.run_start = (pos == '0) && (!dir_r || col_r == '0);
    status.ch_last   = ch_r == 2'd3;
    status.out_free  = !out_valid_r || out_ready;
    status.nseg      = adv && seg_more && (spos_inc >= seg_r);
  end

  assign out_valid = out_valid_r;
  assign pix_red   = pix_r[0];
  assign pix_green = pix_r[1];
  assign pix_blue  = pix_r[2];
  assign pix_alpha = pix_r[3];
  assign row_end   = row_end_r;
  assign frame_end = frame_end_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready)) else $error("pixel overwrites a held result");
  a_emit_seg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !dirty_r) else $error("pixel emitted with stale segment length");
  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ch_take || cmd.seg_take) |-> div_done) else $error("quotient taken early");
endmodule

FILE: design/mslgg_ctrl.sv
// Controller state machine sequencing loads, divisions and pixel output.
`timescale 1ns / 1ps
module mslgg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  input  mslgg_pkg::dp_status_t status,
  output mslgg_pkg::ctl_cmd_t   cmd
);
  import mslgg_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       ret_out_r, ret_out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_out_r <= ret_out_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ret_out_nxt = ret_out_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.stop_we = 1'b1;
          end else begin
            cmd.norm  = 1'b1;
            state_nxt = status.seg_dirty ? ST_SEG : ST_CHK;
          end
        end
      end
      ST_SEG: begin
        cmd.seg_go = 1'b1;
        state_nxt  = ST_SEGW;
      end
      ST_SEGW: begin
        if (status.div_done) begin
          cmd.seg_take = 1'b1;
          state_nxt    = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status.run_start) begin
          cmd.begin_run = 1'b1;
          ret_out_nxt   = 1'b1;
          state_nxt     = ST_RD0;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.lat0  = 1'b1;
        cmd.rd_hi = 1'b1;
        state_nxt = ST_LAT1;
      end
      ST_LAT1: begin
        cmd.lat1   = 1'b1;
        cmd.ch_clr = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.ch_go = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (status.div_done) begin
          cmd.ch_take = 1'b1;
          if (status.ch_last) begin
            state_nxt = ret_out_r ? ST_OUT : ST_IDLE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.nseg) begin
            ret_out_nxt = 1'b0;
            state_nxt   = ST_RD0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

FILE: sim/tb_multi_stop_linear_gradient_generator.sv
// Self-checking testbench of the multi-stop linear gradient generator.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       row_end;
  logic       frame_end;
} pixel_t;

// Mirrors the generator state and holds the pixels still owed by the block.
class gradient_scoreboard;
  localparam int unsigned MAXS = 16;
  localparam int unsigned MAXD = 4096;
  localparam longint      UNIT = 65793;

  logic [31:0] stops [MAXS];
  logic [25:0] acc [4];
  logic [25:0] step [4];
  int unsigned col, row, seg_idx, seg_pos;
  int unsigned width_reg, height_reg, dir_reg, count_reg;
  pixel_t      owed[$];
  int          mismatches;

  function new();
    foreach (stops[i]) stops[i] = '0;
    foreach (acc[i]) begin
      acc[i]  = '0;
      step[i] = '0;
    end
    col = 0; row = 0; seg_idx = 0; seg_pos = 0;
    width_reg = 1; height_reg = 1; dir_reg = 0; count_reg = 2;
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] addr, logic [12:0] data);
    case (addr)
      mslgg_pkg::REG_FRAME_WIDTH:  width_reg  = data;
      mslgg_pkg::REG_FRAME_HEIGHT: height_reg = data;
      mslgg_pkg::REG_DIRECTION:    dir_reg    = data[0];
      mslgg_pkg::REG_STOP_COUNT:   count_reg  = data[4:0];
      default: ;
    endcase
  endfunction

  function automatic longint chan(int unsigned idx, int unsigned ch);
    if (idx >= MAXS) return 0;
    return longint'(stops[idx][8*ch +: 8]);
  endfunction

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void open_segment(int unsigned s, int unsigned cnt, int unsigned seg);
    longint c0, st;
    seg_idx = s;
    seg_pos = 0;
    for (int ch = 0; ch < 4; ch++) begin
      c0 = chan(s, ch);
      st = 0;
      if (s + 1 < cnt) st = ((chan(s + 1, ch) - c0) * UNIT) / longint'(seg);
      acc[ch]  = 26'(c0 * UNIT);
      step[ch] = 26'(st);
    end
  endfunction

  // Note one accepted input transfer; a produce owes one pixel.
  function void note_item(logic cmd, logic [3:0] idx, logic [31:0] colour);
    int unsigned w, h, len, pos, n, cnt, seg, second;
    bit vert, multi, rend, fend;
    longint c0, c1;
    pixel_t px;
    if (cmd == mslgg_pkg::CMD_LOAD) begin
      stops[idx] = colour;
      return;
    end
    w = clampv(width_reg, MAXD);
    h = clampv(height_reg, MAXD);
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    vert  = dir_reg[0];
    len   = vert ? h : w;
    pos   = vert ? row : col;
    n     = clampv(count_reg, MAXS);
    multi = n > 2;
    cnt   = (n < len) ? n : len;
    seg   = (cnt > 1) ? len / (cnt - 1) : len;
    if (seg == 0) seg = 1;
    // Reload accumulators and steps at the head of each run along the axis.
    if (pos == 0 && (!vert || col == 0)) begin
      if (multi) open_segment(0, cnt, seg);
      else begin
        second = (n >= 2) ? 1 : 0;
        seg_idx = 0;
        seg_pos = 0;
        for (int ch = 0; ch < 4; ch++) begin
          c0 = chan(0, ch);
          c1 = chan(second, ch);
          acc[ch]  = 26'(c0 * 65536);
          step[ch] = 26'(((c1 - c0) * 65536) / longint'(len));
        end
      end
    end
    rend = (col == w - 1);
    fend = rend && (row == h - 1);
    px.red       = acc[0][23:16];
    px.green     = acc[1][23:16];
    px.blue      = acc[2][23:16];
    px.alpha     = acc[3][23:16];
    px.row_end   = rend;
    px.frame_end = fend;
    owed.push_back(px);
    if (!vert || rend) begin
      for (int ch = 0; ch < 4; ch++) acc[ch] = acc[ch] + step[ch];
      if (multi && seg_idx + 1 < cnt) begin
        seg_pos = (seg_pos + 1) & 13'h1fff;
        if (seg_pos >= seg) open_segment(seg_idx + 1, cnt, seg);
      end
    end
    if (rend) begin
      col = 0;
      row = fend ? 0 : row + 1;
    end else begin
      col++;
    end
  endfunction

  function void check_pixel(pixel_t got);
    pixel_t want;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pixel %h", got);
      return;
    end
    want = owed.pop_front();
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.alpha !== want.alpha || got.row_end !== want.row_end ||
        got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: expected r%h g%h b%h a%h re%b fe%b, got r%h g%h b%h a%h re%b fe%b",
                 want.red, want.green, want.blue, want.alpha, want.row_end, want.frame_end,
                 got.red, got.green, got.blue, got.alpha, got.row_end, got.frame_end);
    end
  endfunction
endclass

module tb_multi_stop_linear_gradient_generator;
  import mslgg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE      = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [12:0] cfg_wdata;
  int unsigned cycles;

  mslgg_in_if  in_chan ();
  mslgg_out_if out_chan ();

  gradient_scoreboard sb = new();

  multi_stop_linear_gradient_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort the run once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: draw a stall per pixel, then hold ready until the transfer.
  initial begin
    pixel_t      got;
    int unsigned stall;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      repeat (stall) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.red       = out_chan.pix_red;
      got.green     = out_chan.pix_green;
      got.blue      = out_chan.pix_blue;
      got.alpha     = out_chan.pix_alpha;
      got.row_end   = out_chan.row_end;
      got.frame_end = out_chan.frame_end;
      sb.check_pixel(got);
    end
  end

  // Present one item after a random gap and hold it until the transfer.
  task automatic send_item(logic cmd, logic [3:0] idx, logic [31:0] colour,
                           bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= cmd;
    in_chan.stop_index <= idx;
    in_chan.stop_red   <= colour[7:0];
    in_chan.stop_green <= colour[15:8];
    in_chan.stop_blue  <= colour[23:16];
    in_chan.stop_alpha <= colour[31:24];
    do @(posedge clk); while (!in_chan.ready);
    sb.note_item(cmd, idx, colour);
  endtask

  // Drop valid, drain every owed pixel, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [12:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h, logic d, logic [12:0] n);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_DIRECTION, {12'd0, d});
    write_reg(REG_STOP_COUNT, n);
  endtask

  // Run one phase: mostly pixel requests, some stop loads mid-frame.
  task automatic run_phase(int unsigned items);
    bit burst;
    for (int i = 0; i < items; i++) begin
      burst = ($urandom_range(0, 9) < 2);
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_LOAD, 4'($urandom_range(0, 15)), $urandom(), burst);
      else
        send_item(CMD_PRODUCE, 4'($urandom()), $urandom(), burst);
    end
    drain();
  endtask

  initial begin
    logic [12:0] w, h, n;
    cycles          = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_chan.valid      = 1'b0;
    in_chan.cmd        = CMD_LOAD;
    in_chan.stop_index = '0;
    in_chan.stop_red   = '0;
    in_chan.stop_green = '0;
    in_chan.stop_blue  = '0;
    in_chan.stop_alpha = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every stop so that no unwritten entry is ever read; alternate
    // black and white so the first segments swing over the full range.
    for (int s = 0; s < 16; s++)
      send_item(CMD_LOAD, 4'(s), (s % 2 == 0) ? 32'h0000_0000 : 32'hffff_ffff, 1'b0);
    // Reset configuration: a 1x1 frame of two stops.
    send_item(CMD_PRODUCE, 4'd0, 32'd0, 1'b0);
    send_item(CMD_PRODUCE, 4'd15, 32'hffff_ffff, 1'b0);
    drain();

    // Directed extremes: widest row, tallest column, out-of-range registers,
    // one stop, three stops on a short vertical axis, and two stops.
    set_frame(13'd4096, 13'd1, 1'b0, 13'd16); run_phase(20);
    set_frame(13'd1, 13'd4096, 1'b1, 13'd16); run_phase(20);
    set_frame(13'd0, 13'd0, 1'b0, 13'd0);     run_phase(6);
    set_frame(13'h1fff, 13'h1fff, 1'b1, 13'd31); run_phase(12);
    set_frame(13'd5, 13'd3, 1'b0, 13'd1);     run_phase(16);
    set_frame(13'd2, 13'd4, 1'b1, 13'd3);     run_phase(16);
    set_frame(13'd7, 13'd2, 1'b0, 13'd2);     run_phase(16);

    // Random phases: small frames mostly so that frames wrap often.
    for (int p = 0; p < 24; p++) begin
      w = 13'($urandom_range(1, 24));
      h = 13'($urandom_range(1, 12));
      n = 13'($urandom_range(1, 16));
      if ($urandom_range(0, 7) == 0) w = 13'($urandom());
      if ($urandom_range(0, 7) == 0) h = 13'($urandom());
      if ($urandom_range(0, 7) == 0) n = 13'($urandom_range(0, 31));
      set_frame(w, h, 1'($urandom()), n);
      run_phase(64);
    end

    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: multi_stop_linear_gradient_generator.f
design/mslgg_pkg.sv
design/mslgg_if.sv
design/mslgg_ram.sv
design/mslgg_div.sv
design/mslgg_dp.sv
design/mslgg_ctrl.sv
design/multi_stop_linear_gradient_generator.sv
sim/tb_multi_stop_linear_gradient_generator.sv
